// File: rtl/core/rsfl_pkg.sv
// ----------------------------------------------------------------------------
// rsfl_pkg
// Shared widths, codes and controller/datapath types for the range-split
// fifo/lifo averager.
// ----------------------------------------------------------------------------
package rsfl_pkg;

    localparam int RSFL_DEPTH   = 32;

    localparam int MODE_W       = 2;
    localparam int VALUE_IN_W   = 16;
    localparam int STATUS_W     = 3;
    localparam int VALUE_OUT_W  = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_DATA_W-1:0] SPLIT_RESET = 8'd50;
    localparam logic [CFG_DATA_W-1:0] UPPER_RESET = 8'd99;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_PUSH       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAIN_FIFO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAIN_LIFO = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STACKED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_AVERAGE = 3'd5;

    localparam logic SRC_FIFO = 1'b0;
    localparam logic SRC_LIFO = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_DRN_RD,
        S_DRN_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_AVG
    } t_state;

    typedef struct packed {
        logic accept;
        logic push;
        logic rd_issue;
        logic consume;
        logic div_start;
        logic load_avg;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic cnt_gt1;
        logic div_busy;
    } t_dp_stat;

endpackage

// File: rtl/core/rsfl_if.sv
// ----------------------------------------------------------------------------
// rsfl_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rsfl_item_if import rsfl_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic        [MODE_W-1:0]     mode;
    logic signed [VALUE_IN_W-1:0] value_in;

    modport source (output valid, output mode, output value_in, input ready);
    modport sink   (input valid, input mode, input value_in, output ready);
endinterface

interface rsfl_result_if import rsfl_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [VALUE_OUT_W-1:0] value_out;
    logic                   src;
    logic                   last;

    modport source (output valid, output status, output value_out, output src,
                    output last, input ready);
    modport sink   (input valid, input status, input value_out, input src,
                    input last, output ready);
endinterface

// File: rtl/core/range_split_fifo_lifo_averager.sv
// ----------------------------------------------------------------------------
// range_split_fifo_lifo_averager
// Range check, split into a fifo or a lifo, drain with a truncated average.
//
//   channel   dir   handshake      payload
//   i_item    in    valid/ready    mode, value_in
//   o_result  out   valid/ready    status, value_out, src, last
//   i_cfg_*   in    write enable   idx (0 split_point, 1 upper_limit), data
//
// a push: accept, then the status beat is loaded
// a drain of n entries: accept, first store read, one entry beat a cycle while
// the result register is free, divider start, SW divider steps of one bit each,
// a wait state to see it idle, the average beat; SW = 8 + clog2(DEPTH+1) (14 at
// depth 32)
// reset clears counts, pointers, config registers and the result valid; store contents stay undefined
// a stalled result only holds the block once its next beat is due
// ----------------------------------------------------------------------------
module range_split_fifo_lifo_averager import rsfl_pkg::*; #(
    parameter int DEPTH = RSFL_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rsfl_item_if.sink             i_item,
    rsfl_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rsfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_mode  (i_item.mode),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rsfl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_item.mode),
        .i_value      (i_item.value_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_out_status (o_result.status),
        .o_out_value  (o_result.value_out),
        .o_out_source (o_result.src),
        .o_out_last   (o_result.last)
    );

endmodule

// File: rtl/core/rsfl_ram.sv
// ----------------------------------------------------------------------------
// rsfl_ram
// Simple dual-port RAM, one write and one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
module rsfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rsfl_div.sv
// ----------------------------------------------------------------------------
// rsfl_div
// Restoring divider, one quotient bit per cycle, for the drain average.
// ----------------------------------------------------------------------------
module rsfl_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            // shift the next dividend bit in, keep the quotient bit in its place
            n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// File: rtl/core/rsfl_dp.sv
// ----------------------------------------------------------------------------
// rsfl_dp
// Datapath: config registers, both stores with their pointers and counts,
// drain sum, divider and the result register.
// ----------------------------------------------------------------------------
module rsfl_dp import rsfl_pkg::*; #(
    parameter int DEPTH = RSFL_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat,
    input  logic        [MODE_W-1:0]     i_mode,
    input  logic signed [VALUE_IN_W-1:0] i_value,
    input  logic                         i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic        [STATUS_W-1:0]   o_out_status,
    output logic        [VALUE_OUT_W-1:0] o_out_value,
    output logic                         o_out_source,
    output logic                         o_out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = VALUE_OUT_W + CW;

    logic [CFG_DATA_W-1:0]  r_split, r_upper;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_fifo_cnt, n_fifo_cnt;
    logic [CW-1:0]          r_lifo_cnt, n_lifo_cnt;
    logic [VALUE_IN_W-1:0]  r_val;
    logic                   r_src;
    logic [SW-1:0]          r_sum, n_sum;
    logic [CW-1:0]          r_n, n_n;

    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_out_status, n_out_status;
    logic [VALUE_OUT_W-1:0] r_out_value, n_out_value;
    logic                   r_out_source, n_out_source;
    logic                   r_out_last, n_out_last;

    logic                   out_free;
    logic [AW-1:0]          head_inc;
    logic [CW:0]            tail_sum;
    logic [AW-1:0]          tail;
    logic                   invalid, to_fifo, fifo_full, lifo_full;
    logic [CW-1:0]          sel_cnt;
    logic                   fifo_we, lifo_we;
    logic [AW-1:0]          fifo_raddr, lifo_raddr;
    logic [VALUE_OUT_W-1:0] fifo_rdata, lifo_rdata, rdata;
    logic                   div_busy;
    logic [SW-1:0]          quo;

    assign out_free = !r_out_valid || i_out_ready;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // tail = (head + count) mod depth, the sum stays below twice the depth
    assign tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_fifo_cnt);
    assign tail     = (tail_sum >= (CW + 1)'(DEPTH)) ? AW'(tail_sum - (CW + 1)'(DEPTH))
                                                     : AW'(tail_sum);

    assign invalid   = r_val[VALUE_IN_W-1] || (r_val[VALUE_IN_W-2:0] >
                       (VALUE_IN_W - 1)'(r_upper));
    assign to_fifo   = r_val[VALUE_OUT_W-1:0] < r_split;
    assign fifo_full = r_fifo_cnt == CW'(DEPTH);
    assign lifo_full = r_lifo_cnt == CW'(DEPTH);
    assign sel_cnt   = r_src ? r_lifo_cnt : r_fifo_cnt;

    assign fifo_we    = i_cmd.push && !invalid && to_fifo && !fifo_full;
    assign lifo_we    = i_cmd.push && !invalid && !to_fifo && !lifo_full;
    assign fifo_raddr = i_cmd.consume ? head_inc : r_head;
    assign lifo_raddr = i_cmd.consume ? AW'(r_lifo_cnt - CW'(2)) : AW'(r_lifo_cnt - CW'(1));
    assign rdata      = r_src ? lifo_rdata : fifo_rdata;

    rsfl_ram #(
        .WIDTH (VALUE_OUT_W),
        .DEPTH (DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (tail),
        .i_wdata (r_val[VALUE_OUT_W-1:0]),
        .i_re    (i_cmd.rd_issue && !r_src),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    rsfl_ram #(
        .WIDTH (VALUE_OUT_W),
        .DEPTH (DEPTH)
    ) u_lifo_ram (
        .i_clk   (i_clk),
        .i_we    (lifo_we),
        .i_waddr (AW'(r_lifo_cnt)),
        .i_wdata (r_val[VALUE_OUT_W-1:0]),
        .i_re    (i_cmd.rd_issue && r_src),
        .i_raddr (lifo_raddr),
        .o_rdata (lifo_rdata)
    );

    rsfl_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sum),
        .i_den   (r_n),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    always_comb begin
        n_head       = r_head;
        n_fifo_cnt   = r_fifo_cnt;
        n_lifo_cnt   = r_lifo_cnt;
        n_sum        = r_sum;
        n_n          = r_n;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_source = r_out_source;
        n_out_last   = r_out_last;

        if (i_cmd.accept) begin
            n_sum = '0;
            n_n   = '0;
        end

        if (i_cmd.push) begin
            n_out_valid = 1'b1;
            n_out_value = '0;
            n_out_last  = 1'b1;
            if (invalid) begin
                n_out_status = ST_INVALID;
                n_out_source = SRC_FIFO;
            end else if (to_fifo) begin
                n_out_source = SRC_FIFO;
                n_out_status = fifo_full ? ST_FULL : ST_QUEUED;
                if (!fifo_full) begin
                    n_fifo_cnt = r_fifo_cnt + 1'b1;
                end
            end else begin
                n_out_source = SRC_LIFO;
                n_out_status = lifo_full ? ST_FULL : ST_STACKED;
                if (!lifo_full) begin
                    n_lifo_cnt = r_lifo_cnt + 1'b1;
                end
            end
        end

        if (i_cmd.consume) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_ENTRY;
            n_out_value  = rdata;
            n_out_source = r_src;
            n_out_last   = 1'b0;
            n_sum        = r_sum + SW'(rdata);
            n_n          = r_n + 1'b1;
            if (r_src) begin
                n_lifo_cnt = r_lifo_cnt - 1'b1;
            end else begin
                n_head     = head_inc;
                n_fifo_cnt = r_fifo_cnt - 1'b1;
            end
        end

        if (i_cmd.load_avg) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_AVERAGE;
            // an empty drain averages to zero
            n_out_value  = (r_n == '0) ? '0 : quo[VALUE_OUT_W-1:0];
            n_out_source = r_src;
            n_out_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split     <= SPLIT_RESET;
            r_upper     <= UPPER_RESET;
            r_head      <= '0;
            r_fifo_cnt  <= '0;
            r_lifo_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_SPLIT) begin
                r_split <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_UPPER) begin
                r_upper <= i_cfg_data;
            end
            r_head      <= n_head;
            r_fifo_cnt  <= n_fifo_cnt;
            r_lifo_cnt  <= n_lifo_cnt;
            r_out_valid <= n_out_valid;
        end
        if (i_cmd.accept) begin
            r_val <= i_value;
            r_src <= (i_mode == MODE_DRAIN_LIFO);
        end
        r_sum        <= n_sum;
        r_n          <= n_n;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_source <= n_out_source;
        r_out_last   <= n_out_last;
    end

    assign o_stat.out_free = out_free;
    assign o_stat.cnt_zero = sel_cnt == '0;
    assign o_stat.cnt_gt1  = sel_cnt > CW'(1);
    assign o_stat.div_busy = div_busy;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_value  = r_out_value;
    assign o_out_source = r_out_source;
    assign o_out_last   = r_out_last;

    a_fifo_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= CW'(DEPTH))
        else $error("fifo count beyond depth");

    a_lifo_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lifo_cnt <= CW'(DEPTH))
        else $error("lifo count beyond depth");

    a_load_into_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push || i_cmd.consume || i_cmd.load_avg) |-> out_free)
        else $error("result register overwritten before its beat was taken");

    a_consume_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.consume |-> sel_cnt != '0)
        else $error("drain step on an empty store");

endmodule

// File: rtl/core/rsfl_ctrl.sv
// ----------------------------------------------------------------------------
// rsfl_ctrl
// Controller: takes one item at a time and sequences push, drain walk,
// divide and average beat.
// ----------------------------------------------------------------------------
module rsfl_ctrl import rsfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_in_mode,
    output logic              o_in_ready,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_in_mode)
                        MODE_PUSH:       n_state = S_PUSH;
                        MODE_DRAIN_FIFO: n_state = S_DRN_RD;
                        MODE_DRAIN_LIFO: n_state = S_DRN_RD;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DRN_RD: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_DIV_GO;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_DRN_WAIT;
                end
            end
            S_DRN_WAIT: begin
                // read data is ready, next read goes out with this beat if more than one entry is left
                if (i_stat.out_free) begin
                    o_cmd.consume = 1'b1;
                    if (i_stat.cnt_gt1) begin
                        o_cmd.rd_issue = 1'b1;
                    end else begin
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                if (i_stat.out_free) begin
                    o_cmd.load_avg = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_div_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_stat.div_busy)
        else $error("divider did not start");

endmodule
